// ===== src/bxd_pkg.sv =====
// shared types and constants for the box area downscaler
// no dependencies
package bxd_pkg;

    // default maximum image size
    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    // register file
    localparam int REG_W    = 13;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;
    localparam int SIZE_RST = 256;

    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [1:0] REG_DST_HEIGHT = 2'd3;

    // pixel and accumulator sizes
    localparam int PIX_W   = 8;
    localparam int CHAN    = 4;
    localparam int SUM_W   = 32;
    localparam int QUO_W   = 8;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        F_START,
        F_WAIT,
        F_RUN
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_ACC,
        B_DIV,
        B_DONE
    } back_state_t;

    // per pixel classification handed from front to back
    typedef struct packed {
        logic fresh;
        logic emit;
        logic last_col;
        logic last_frame;
    } bxd_flags_t;

endpackage

// ===== src/bxd_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module bxd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/bxd_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
// no dependencies
module bxd_div #(
    parameter int W = 13,
    localparam int CNT_W = $clog2(W + 1)
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] num,
    input  logic [W-1:0] den,
    output logic         busy,
    output logic [W-1:0] quo,
    output logic [W-1:0] rem
);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic [W:0]       trial;
    logic             fits;

    // one shift and subtract step
    always_comb begin
        trial     = {rem_reg, quo_reg[W-1]};
        fits      = trial >= {1'b0, den};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(W);
            quo_next  = num;
            rem_next  = '0;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[W-2:0], fits};
            rem_next  = fits ? W'(trial - {1'b0, den}) : W'(trial);
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = cnt_reg != CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ===== src/bxd_queue.sv =====
// short fifo between the front and the back
// no dependencies
module bxd_queue #(
    parameter int W = 8,
    parameter int DEPTH = 2,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] head,
    output logic         not_empty,
    output logic         full
);

    logic [W-1:0]     slot_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, rptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + PW'(1));
    endfunction

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= bump(wptr_reg);
            end
            if (pop) begin
                rptr_reg <= bump(rptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    assign head      = slot_reg[rptr_reg];
    assign not_empty = count_reg != '0;
    assign full      = count_reg == CNT_W'(DEPTH);

endmodule

// ===== src/bxd_front.sv =====
// front end: size registers, boundary setup and per pixel classification
// depends on bxd_pkg and bxd_div
module bxd_front #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_HEIGHT = 4096,
    localparam int CW = $clog2(MAX_WIDTH + 1),
    localparam int RW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bxd_pkg::ADDR_W-1:0]   paddr,
    input  logic [bxd_pkg::DATA_W-1:0]   pwdata,
    output logic [bxd_pkg::DATA_W-1:0]   prdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_frame_start,
    input  logic                         q_full,
    output logic                         q_push,
    output bxd_pkg::bxd_flags_t          q_flags,
    output logic [CW-1:0]                q_col,
    output logic [CW-1:0]                q_box_w,
    output logic [RW-1:0]                q_box_h
);

    import bxd_pkg::*;

    logic [REG_W-1:0] src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
    front_state_t     state_reg, state_next;

    logic [CW-1:0] sw, dw, qw, rw;
    logic [RW-1:0] sh, dh, qh, rh;
    logic          busy_w, busy_h, div_start, load_frame, accept, cfg_wr;

    logic [CW-1:0] sc_reg, oc_reg, bcs_reg, bce_reg, remc_reg;
    logic [RW-1:0] sr_reg, or_reg, brs_reg, bre_reg, remr_reg;
    logic [CW-1:0] sc_next, oc_next, bcs_next, bce_next, remc_next;
    logic [RW-1:0] sr_next, or_next, brs_next, bre_next, remr_next;
    logic [CW-1:0] cur_sc, cur_oc, cur_bcs, cur_bce, cur_remc, sc_inc;
    logic [RW-1:0] cur_sr, cur_or, cur_brs, cur_bre, cur_remr, sr_inc;
    logic [CW:0]   col_sum;
    logic [RW:0]   row_sum;
    logic          col_carry, row_carry;
    logic [CW-1:0] nbce, nremc;
    logic [RW-1:0] nbre, nremr;

    // register writes and reads
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_w_reg <= REG_W'(SIZE_RST);
            src_h_reg <= REG_W'(SIZE_RST);
            dst_w_reg <= REG_W'(SIZE_RST);
            dst_h_reg <= REG_W'(SIZE_RST);
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_SRC_WIDTH:  src_w_reg <= pwdata[REG_W-1:0];
                REG_SRC_HEIGHT: src_h_reg <= pwdata[REG_W-1:0];
                REG_DST_WIDTH:  dst_w_reg <= pwdata[REG_W-1:0];
                REG_DST_HEIGHT: dst_h_reg <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SRC_WIDTH:  prdata = DATA_W'(src_w_reg);
            REG_SRC_HEIGHT: prdata = DATA_W'(src_h_reg);
            REG_DST_WIDTH:  prdata = DATA_W'(dst_w_reg);
            REG_DST_HEIGHT: prdata = DATA_W'(dst_h_reg);
            default:        prdata = '0;
        endcase
    end

    // clamped sizes
    assign sw = (src_w_reg == '0) ? CW'(1) :
                (32'(src_w_reg) > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(src_w_reg);
    assign sh = (src_h_reg == '0) ? RW'(1) :
                (32'(src_h_reg) > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : RW'(src_h_reg);
    assign dw = (dst_w_reg == '0) ? CW'(1) :
                (32'(dst_w_reg) > 32'(sw)) ? sw : CW'(dst_w_reg);
    assign dh = (dst_h_reg == '0) ? RW'(1) :
                (32'(dst_h_reg) > 32'(sh)) ? sh : RW'(dst_h_reg);

    // step size and remainder of the box boundaries
    bxd_div #(.W(CW)) u_div_w (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(sw), .den(dw), .busy(busy_w), .quo(qw), .rem(rw)
    );

    bxd_div #(.W(RW)) u_div_h (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(sh), .den(dh), .busy(busy_h), .quo(qh), .rem(rh)
    );

    // setup sequencer: next state
    always_comb begin
        state_next = state_reg;
        if (cfg_wr) begin
            state_next = F_START;
        end else begin
            case (state_reg)
                F_START: state_next = F_WAIT;
                F_WAIT:  if (!busy_w && !busy_h) state_next = F_RUN;
                F_RUN:   state_next = F_RUN;
                default: state_next = F_START;
            endcase
        end
    end

    // setup sequencer: outputs
    always_comb begin
        div_start  = state_reg == F_START;
        load_frame = (state_reg == F_WAIT) && !busy_w && !busy_h;
        s_ready    = (state_reg == F_RUN) && !q_full;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_START;
        end else begin
            state_reg <= state_next;
        end
    end

    assign accept = s_valid && s_ready;

    // position as seen by this word, after an optional frame restart
    always_comb begin
        cur_sc   = s_frame_start ? '0 : sc_reg;
        cur_oc   = s_frame_start ? '0 : oc_reg;
        cur_bcs  = s_frame_start ? '0 : bcs_reg;
        cur_bce  = s_frame_start ? qw : bce_reg;
        cur_remc = s_frame_start ? rw : remc_reg;
        cur_sr   = s_frame_start ? '0 : sr_reg;
        cur_or   = s_frame_start ? '0 : or_reg;
        cur_brs  = s_frame_start ? '0 : brs_reg;
        cur_bre  = s_frame_start ? qh : bre_reg;
        cur_remr = s_frame_start ? rh : remr_reg;
        sc_inc   = CW'(cur_sc + CW'(1));
        sr_inc   = RW'(cur_sr + RW'(1));
    end

    // classification of the word
    always_comb begin
        q_push              = accept;
        q_flags.fresh       = (cur_sr == cur_brs) && (cur_sc == cur_bcs);
        q_flags.emit        = (sr_inc == cur_bre) && (sc_inc == cur_bce);
        q_flags.last_col    = CW'(cur_oc + CW'(1)) == dw;
        q_flags.last_frame  = q_flags.last_col && (RW'(cur_or + RW'(1)) == dh);
        q_col               = cur_oc;
        q_box_w             = CW'(cur_bce - cur_bcs);
        q_box_h             = RW'(cur_bre - cur_brs);
    end

    // next box boundaries by remainder stepping
    always_comb begin
        col_sum   = {1'b0, cur_remc} + {1'b0, rw};
        col_carry = col_sum >= {1'b0, dw};
        nbce      = CW'(cur_bce + qw + CW'(col_carry));
        nremc     = col_carry ? CW'(col_sum - {1'b0, dw}) : CW'(col_sum);
        row_sum   = {1'b0, cur_remr} + {1'b0, rh};
        row_carry = row_sum >= {1'b0, dh};
        nbre      = RW'(cur_bre + qh + RW'(row_carry));
        nremr     = row_carry ? RW'(row_sum - {1'b0, dh}) : RW'(row_sum);
    end

    // position update
    always_comb begin
        sc_next   = sc_inc;
        oc_next   = cur_oc;
        bcs_next  = cur_bcs;
        bce_next  = cur_bce;
        remc_next = cur_remc;
        sr_next   = cur_sr;
        or_next   = cur_or;
        brs_next  = cur_brs;
        bre_next  = cur_bre;
        remr_next = cur_remr;
        if (sc_inc >= sw) begin
            sc_next   = '0;
            oc_next   = '0;
            bcs_next  = '0;
            bce_next  = qw;
            remc_next = rw;
            sr_next   = sr_inc;
            if (sr_inc >= sh) begin
                sr_next   = '0;
                or_next   = '0;
                brs_next  = '0;
                bre_next  = qh;
                remr_next = rh;
            end else if (sr_inc >= cur_bre) begin
                or_next   = RW'(cur_or + RW'(1));
                brs_next  = cur_bre;
                bre_next  = nbre;
                remr_next = nremr;
            end
        end else if (sc_inc >= cur_bce) begin
            oc_next   = CW'(cur_oc + CW'(1));
            bcs_next  = cur_bce;
            bce_next  = nbce;
            remc_next = nremc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_reg   <= '0;
            oc_reg   <= '0;
            bcs_reg  <= '0;
            bce_reg  <= '0;
            remc_reg <= '0;
            sr_reg   <= '0;
            or_reg   <= '0;
            brs_reg  <= '0;
            bre_reg  <= '0;
            remr_reg <= '0;
        end else if (load_frame) begin
            sc_reg   <= '0;
            oc_reg   <= '0;
            bcs_reg  <= '0;
            bce_reg  <= qw;
            remc_reg <= rw;
            sr_reg   <= '0;
            or_reg   <= '0;
            brs_reg  <= '0;
            bre_reg  <= qh;
            remr_reg <= rh;
        end else if (accept) begin
            sc_reg   <= sc_next;
            oc_reg   <= oc_next;
            bcs_reg  <= bcs_next;
            bce_reg  <= bce_next;
            remc_reg <= remc_next;
            sr_reg   <= sr_next;
            or_reg   <= or_next;
            brs_reg  <= brs_next;
            bre_reg  <= bre_next;
            remr_reg <= remr_next;
        end
    end

endmodule

// ===== src/bxd_back.sv =====
// back end: column sum line, box average divider and output register
// depends on bxd_pkg and bxd_ram
module bxd_back #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_HEIGHT = 4096,
    localparam int CW = $clog2(MAX_WIDTH + 1),
    localparam int RW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         q_not_empty,
    output logic                                         q_pop,
    input  bxd_pkg::bxd_flags_t                          q_flags,
    input  logic [CW-1:0]                                q_col,
    input  logic [CW-1:0]                                q_box_w,
    input  logic [RW-1:0]                                q_box_h,
    input  logic [bxd_pkg::CHAN-1:0][bxd_pkg::PIX_W-1:0] q_pix,
    output logic                                         m_valid,
    input  logic                                         m_ready,
    output logic [bxd_pkg::CHAN-1:0][bxd_pkg::PIX_W-1:0] m_pix,
    output logic                                         m_row_end,
    output logic                                         m_frame_end
);

    import bxd_pkg::*;

    localparam int LAW = $clog2(MAX_WIDTH);
    localparam int AW  = CW + RW;
    localparam int DW  = (AW + QUO_W > SUM_W) ? AW + QUO_W : SUM_W;
    localparam int KW  = $clog2(QUO_W);

    back_state_t state_reg, state_next;

    bxd_flags_t                    flags_reg;
    logic [CW-1:0]                 col_reg;
    logic [CW-1:0]                 box_w_reg;
    logic [RW-1:0]                 box_h_reg;
    logic [CHAN-1:0][PIX_W-1:0]    pix_reg;
    logic [CHAN-1:0][SUM_W-1:0]    sum_reg, sum_next, acc, rdata;
    logic [CHAN-1:0][QUO_W-1:0]    quo_reg, quo_next;
    logic [AW-1:0]                 area_reg;
    logic [KW-1:0]                 k_reg;
    logic [DW-1:0]                 trial;
    logic                          ram_we, load_out;
    logic                          m_valid_reg, row_end_reg, frame_end_reg;
    logic [CHAN-1:0][PIX_W-1:0]    out_pix_reg;

    // sum line, all four channels in one word
    bxd_ram #(.WIDTH(CHAN * SUM_W), .DEPTH(MAX_WIDTH)) u_line (
        .aclk(aclk),
        .we(ram_we),
        .waddr(col_reg[LAW-1:0]),
        .wdata(acc),
        .raddr(q_col[LAW-1:0]),
        .rdata(rdata)
    );

    // sequencer: next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: if (q_not_empty) state_next = B_ACC;
            B_ACC:  state_next = flags_reg.emit ? B_DIV : B_IDLE;
            B_DIV:  if (k_reg == '0) state_next = B_DONE;
            B_DONE: if (!m_valid_reg || m_ready) state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        q_pop    = (state_reg == B_IDLE) && q_not_empty;
        ram_we   = state_reg == B_ACC;
        load_out = (state_reg == B_DONE) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // accumulate the word into its column sum
    always_comb begin
        for (int c = 0; c < CHAN; c++) begin
            acc[c] = flags_reg.fresh ? SUM_W'(pix_reg[c]) : rdata[c] + SUM_W'(pix_reg[c]);
        end
    end

    // one quotient bit per channel per cycle, high bit first
    always_comb begin
        trial = DW'(area_reg) << k_reg;
        for (int c = 0; c < CHAN; c++) begin
            if (DW'(sum_reg[c]) >= trial) begin
                sum_next[c] = SUM_W'(DW'(sum_reg[c]) - trial);
                quo_next[c] = {quo_reg[c][QUO_W-2:0], 1'b1};
            end else begin
                sum_next[c] = sum_reg[c];
                quo_next[c] = {quo_reg[c][QUO_W-2:0], 1'b0};
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            flags_reg <= q_flags;
            col_reg   <= q_col;
            box_w_reg <= q_box_w;
            box_h_reg <= q_box_h;
            pix_reg   <= q_pix;
        end
        if (state_reg == B_ACC) begin
            sum_reg  <= acc;
            area_reg <= AW'(box_w_reg * box_h_reg);
            k_reg    <= KW'(QUO_W - 1);
            quo_reg  <= '0;
        end else if (state_reg == B_DIV) begin
            sum_reg <= sum_next;
            quo_reg <= quo_next;
            k_reg   <= k_reg - KW'(1);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (load_out) begin
            out_pix_reg   <= quo_reg;
            row_end_reg   <= flags_reg.last_col;
            frame_end_reg <= flags_reg.last_frame;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_pix       = out_pix_reg;
    assign m_row_end   = row_end_reg;
    assign m_frame_end = frame_end_reg;

endmodule

// ===== src/box_area_downscaler.sv =====
// RGBA8 box-filter downscaler. Source pixels arrive in raster order and each output
// pixel is the floored per-channel mean of its source box; one result leaves when the
// last pixel of a box arrives, flagged with row_end and frame_end. The front takes one
// pixel per cycle, while the queue has room, into a two-word queue; the back pops one
// pixel at a time, does the read-modify-write of the column sum line, and for a pixel
// that closes a box runs the eight-step average divider and then loads the output
// register before it pops the next. After reset and after every register write the
// block computes box steps with s_ready low; any write also restarts the frame.
// depends on bxd_pkg, bxd_front, bxd_queue, bxd_back
module box_area_downscaler #(
    parameter int MAX_WIDTH = bxd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bxd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bxd_pkg::ADDR_W-1:0] paddr,
    input  logic [bxd_pkg::DATA_W-1:0] pwdata,
    output logic [bxd_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_frame_start,
    input  logic [bxd_pkg::PIX_W-1:0]  s_in_red,
    input  logic [bxd_pkg::PIX_W-1:0]  s_in_green,
    input  logic [bxd_pkg::PIX_W-1:0]  s_in_blue,
    input  logic [bxd_pkg::PIX_W-1:0]  s_in_alpha,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [bxd_pkg::PIX_W-1:0]  m_out_red,
    output logic [bxd_pkg::PIX_W-1:0]  m_out_green,
    output logic [bxd_pkg::PIX_W-1:0]  m_out_blue,
    output logic [bxd_pkg::PIX_W-1:0]  m_out_alpha,
    output logic                       m_row_end,
    output logic                       m_frame_end
);

    import bxd_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int QW = $bits(bxd_flags_t) + 2 * CW + RW + CHAN * PIX_W;

    bxd_flags_t                 f_flags, b_flags;
    logic [CW-1:0]              f_col, f_box_w, b_col, b_box_w;
    logic [RW-1:0]              f_box_h, b_box_h;
    logic [CHAN-1:0][PIX_W-1:0] f_pix, b_pix, m_pix;
    logic                       q_push, q_pop, q_full, q_not_empty;
    logic [QW-1:0]              q_head;

    assign pready = 1'b1;
    assign f_pix  = {s_in_alpha, s_in_blue, s_in_green, s_in_red};

    // classify each accepted word
    bxd_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_frame_start(s_frame_start),
        .q_full(q_full), .q_push(q_push), .q_flags(f_flags),
        .q_col(f_col), .q_box_w(f_box_w), .q_box_h(f_box_h)
    );

    // decoupling queue
    bxd_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .push(q_push), .push_data({f_flags, f_col, f_box_w, f_box_h, f_pix}),
        .pop(q_pop), .head(q_head), .not_empty(q_not_empty), .full(q_full)
    );

    assign {b_flags, b_col, b_box_w, b_box_h, b_pix} = q_head;

    // accumulate and average
    bxd_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_not_empty(q_not_empty), .q_pop(q_pop), .q_flags(b_flags),
        .q_col(b_col), .q_box_w(b_box_w), .q_box_h(b_box_h), .q_pix(b_pix),
        .m_valid(m_valid), .m_ready(m_ready), .m_pix(m_pix),
        .m_row_end(m_row_end), .m_frame_end(m_frame_end)
    );

    assign m_out_red   = m_pix[0];
    assign m_out_green = m_pix[1];
    assign m_out_blue  = m_pix[2];
    assign m_out_alpha = m_pix[3];

    // last pixel of a frame is always the last of its row
    a_frame_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_frame_end || m_row_end))
        else $error("frame_end without row_end");

    // queue never written while full
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push)
        else $error("queue overflow");

    // a register write stalls input while box steps are recomputed
    a_cfg_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite) |=> !s_ready)
        else $error("input taken right after register write");

    // back never pops an empty queue
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_not_empty)
        else $error("queue underflow");

endmodule
